>>> design/tksd_pkg.sv
// tksd_pkg: key codes and the fixed key sequence table of the terminal key decoder
// no dependencies
`default_nettype none

package tksd_pkg;

  localparam int unsigned KEY_COUNT = 22;
  localparam int unsigned ENTRY_W   = 5;
  localparam int unsigned POS_W     = 2;
  localparam int unsigned LEN_W     = 3;
  localparam int unsigned KIND_W    = 5;
  localparam int unsigned BYTE_W    = 8;

  // byte constants
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_SO    = 8'h0e;
  localparam logic [7:0] CH_DLE   = 8'h10;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_F     = 8'h46;

  // key kind codes
  localparam logic [KIND_W-1:0] KIND_REGULAR = 5'd0;
  localparam logic [KIND_W-1:0] KIND_BKSP    = 5'd1;
  localparam logic [KIND_W-1:0] KIND_CTRL_A  = 5'd2;
  localparam logic [KIND_W-1:0] KIND_CTRL_B  = 5'd3;
  localparam logic [KIND_W-1:0] KIND_CTRL_C  = 5'd4;
  localparam logic [KIND_W-1:0] KIND_CTRL_D  = 5'd5;
  localparam logic [KIND_W-1:0] KIND_CTRL_E  = 5'd6;
  localparam logic [KIND_W-1:0] KIND_CTRL_F  = 5'd7;
  localparam logic [KIND_W-1:0] KIND_CTRL_K  = 5'd8;
  localparam logic [KIND_W-1:0] KIND_CTRL_N  = 5'd9;
  localparam logic [KIND_W-1:0] KIND_CTRL_P  = 5'd10;
  localparam logic [KIND_W-1:0] KIND_ENTER   = 5'd11;
  localparam logic [KIND_W-1:0] KIND_INS     = 5'd12;
  localparam logic [KIND_W-1:0] KIND_HOME    = 5'd13;
  localparam logic [KIND_W-1:0] KIND_DEL     = 5'd14;
  localparam logic [KIND_W-1:0] KIND_END     = 5'd15;
  localparam logic [KIND_W-1:0] KIND_PGUP    = 5'd16;
  localparam logic [KIND_W-1:0] KIND_PGDN    = 5'd17;
  localparam logic [KIND_W-1:0] KIND_UP      = 5'd18;
  localparam logic [KIND_W-1:0] KIND_DOWN    = 5'd19;
  localparam logic [KIND_W-1:0] KIND_RIGHT   = 5'd20;
  localparam logic [KIND_W-1:0] KIND_LEFT    = 5'd21;
  localparam logic [KIND_W-1:0] KIND_MAX     = KIND_LEFT;

  typedef struct packed {
    logic [3:0][7:0]    code;   // code[0] is the first byte
    logic [LEN_W-1:0]   len;
    logic [KIND_W-1:0]  kind;
  } seq_entry_t;

  // one decoded word for the result register
  typedef struct packed {
    logic               emit;
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  char_value;
  } key_result_t;

  function automatic seq_entry_t mk(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3,
                                    input logic [LEN_W-1:0] len,
                                    input logic [KIND_W-1:0] kind);
    seq_entry_t e;
    e.code[0] = b0;
    e.code[1] = b1;
    e.code[2] = b2;
    e.code[3] = b3;
    e.len     = len;
    e.kind    = kind;
    return e;
  endfunction

  function automatic seq_entry_t seq_table(input logic [ENTRY_W-1:0] idx);
    seq_entry_t e;
    case (idx)
      5'd0:  e = mk(8'h01, 8'h00, 8'h00, 8'h00, 3'd1, KIND_CTRL_A);
      5'd1:  e = mk(8'h02, 8'h00, 8'h00, 8'h00, 3'd1, KIND_CTRL_B);
      5'd2:  e = mk(8'h03, 8'h00, 8'h00, 8'h00, 3'd1, KIND_CTRL_C);
      5'd3:  e = mk(8'h04, 8'h00, 8'h00, 8'h00, 3'd1, KIND_CTRL_D);
      5'd4:  e = mk(8'h05, 8'h00, 8'h00, 8'h00, 3'd1, KIND_CTRL_E);
      5'd5:  e = mk(8'h06, 8'h00, 8'h00, 8'h00, 3'd1, KIND_CTRL_F);
      5'd6:  e = mk(CH_BS, 8'h00, 8'h00, 8'h00, 3'd1, KIND_BKSP);
      5'd7:  e = mk(CH_VT, 8'h00, 8'h00, 8'h00, 3'd1, KIND_CTRL_K);
      5'd8:  e = mk(CH_CR, 8'h00, 8'h00, 8'h00, 3'd1, KIND_ENTER);
      5'd9:  e = mk(CH_SO, 8'h00, 8'h00, 8'h00, 3'd1, KIND_CTRL_N);
      5'd10: e = mk(CH_DLE, 8'h00, 8'h00, 8'h00, 3'd1, KIND_CTRL_P);
      5'd11: e = mk(CH_ESC, CH_LBRK, 8'h31, CH_TILDE, 3'd4, KIND_HOME);
      5'd12: e = mk(CH_ESC, CH_LBRK, 8'h32, CH_TILDE, 3'd4, KIND_INS);
      5'd13: e = mk(CH_ESC, CH_LBRK, 8'h33, CH_TILDE, 3'd4, KIND_DEL);
      5'd14: e = mk(CH_ESC, CH_ZERO, CH_F, 8'h00, 3'd3, KIND_END);
      5'd15: e = mk(CH_ESC, CH_LBRK, 8'h34, CH_TILDE, 3'd4, KIND_END);
      5'd16: e = mk(CH_ESC, CH_LBRK, 8'h35, CH_TILDE, 3'd4, KIND_PGUP);
      5'd17: e = mk(CH_ESC, CH_LBRK, 8'h36, CH_TILDE, 3'd4, KIND_PGDN);
      5'd18: e = mk(CH_ESC, CH_LBRK, 8'h41, 8'h00, 3'd3, KIND_UP);
      5'd19: e = mk(CH_ESC, CH_LBRK, 8'h42, 8'h00, 3'd3, KIND_DOWN);
      5'd20: e = mk(CH_ESC, CH_LBRK, 8'h43, 8'h00, 3'd3, KIND_RIGHT);
      5'd21: e = mk(CH_ESC, CH_LBRK, 8'h44, 8'h00, 3'd3, KIND_LEFT);
      default: e = mk(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, KIND_REGULAR);
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

>>> design/tksd_matcher.sv
// tksd_matcher: prefix match state and table search for one received byte
// depends on tksd_pkg
`default_nettype none

module tksd_matcher (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step_en,
  input  wire logic [tksd_pkg::BYTE_W-1:0]    rx_byte,
  output tksd_pkg::key_result_t               result
);

  logic [tksd_pkg::ENTRY_W-1:0] match_entry_r, match_entry_nxt;
  logic [tksd_pkg::POS_W-1:0]   match_pos_r, match_pos_nxt;

  tksd_pkg::seq_entry_t         cur_e;
  tksd_pkg::seq_entry_t         hit_e;
  logic [tksd_pkg::KEY_COUNT-1:0] accept;
  logic                         found;
  logic [tksd_pkg::ENTRY_W-1:0] hit_idx;
  logic [tksd_pkg::LEN_W-1:0]   pos_next;

  // entry the pending prefix came from
  always_comb begin
    if (match_entry_r < tksd_pkg::ENTRY_W'(tksd_pkg::KEY_COUNT)) begin
      cur_e = tksd_pkg::seq_table(match_entry_r);
    end else begin
      cur_e = tksd_pkg::seq_table('0);
    end
  end

  // every entry is tested in parallel against the full prefix and the new byte
  always_comb begin
    for (int j = 0; j < tksd_pkg::KEY_COUNT; j++) begin
      tksd_pkg::seq_entry_t e;
      logic ok;
      e  = tksd_pkg::seq_table(tksd_pkg::ENTRY_W'(j));
      ok = (e.len > tksd_pkg::LEN_W'(match_pos_r));
      for (int k = 0; k < 3; k++) begin
        if (tksd_pkg::POS_W'(k) < match_pos_r && e.code[k] != cur_e.code[k]) begin
          ok = 1'b0;
        end
      end
      if (e.code[match_pos_r] != rx_byte) begin
        ok = 1'b0;
      end
      accept[j] = ok;
    end
  end

  // lowest accepting entry wins
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int j = tksd_pkg::KEY_COUNT - 1; j >= 0; j--) begin
      if (accept[j]) begin
        found   = 1'b1;
        hit_idx = tksd_pkg::ENTRY_W'(j);
      end
    end
  end

  always_comb begin
    hit_e    = tksd_pkg::seq_table(hit_idx);
    pos_next = tksd_pkg::LEN_W'(match_pos_r) + 3'd1;
    result.emit       = 1'b1;
    result.kind       = tksd_pkg::KIND_REGULAR;
    result.char_value = rx_byte;
    match_entry_nxt   = '0;
    match_pos_nxt     = '0;
    if (found) begin
      if (pos_next >= hit_e.len) begin
        result.kind       = hit_e.kind;
        result.char_value = '0;
      end else begin
        // partial match, nothing to emit yet
        result.emit     = 1'b0;
        match_entry_nxt = hit_idx;
        match_pos_nxt   = pos_next[tksd_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_entry_r <= '0;
      match_pos_r   <= '0;
    end else if (step_en) begin
      match_entry_r <= match_entry_nxt;
      match_pos_r   <= match_pos_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/terminal_key_sequence_decoder.sv
// terminal_key_sequence_decoder: top level, input register, matcher and result register
// depends on tksd_pkg and tksd_matcher
//
// usage:
//   in channel: one received terminal byte per word on in_rx_byte, valid/ready.
//   out channel: out_key_kind and out_char_value, valid/ready. a byte that
//   completes a key sequence gives that key's code with char_value zero; a
//   byte that extends no pending prefix gives kind regular with the byte;
//   a byte that only extends a prefix gives no word at all.
//   a word accepted into the input register is decoded by the matcher and
//   written into the result register, where the receiver takes it. throughput:
//   one byte per cycle while the receiver does not stall, set by the single
//   table search between the input register and the result register.
//   reset (rst_n low, synchronous) drops any pending prefix and empties both
//   registers. when the receiver stalls, the result register holds its word,
//   the input register keeps one more byte, and in_ready drops only then.
`default_nettype none

module terminal_key_sequence_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output wire logic                          in_ready,
  input  wire logic [tksd_pkg::BYTE_W-1:0]   in_rx_byte,
  output wire logic                          out_valid,
  input  wire logic                          out_ready,
  output wire logic [tksd_pkg::KIND_W-1:0]   out_key_kind,
  output wire logic [tksd_pkg::BYTE_W-1:0]   out_char_value
);

  logic                        s1_valid_r;
  logic [tksd_pkg::BYTE_W-1:0] s1_byte_r;
  logic                        out_valid_r;
  logic [tksd_pkg::KIND_W-1:0] out_kind_r;
  logic [tksd_pkg::BYTE_W-1:0] out_char_r;

  logic                        out_free;
  logic                        s1_adv;
  tksd_pkg::key_result_t       res;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  tksd_matcher u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .rx_byte (s1_byte_r),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_adv && res.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
    if (s1_adv && res.emit) begin
      out_kind_r <= res.kind;
      out_char_r <= res.char_value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_kind   = out_kind_r;
  assign out_char_value = out_char_r;

endmodule

`default_nettype wire

>>> design/tksd_checker.sv
// tksd_checker: port level assertions for terminal_key_sequence_decoder
// depends on tksd_pkg; bound to the top level below
`default_nettype none

module tksd_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [tksd_pkg::BYTE_W-1:0]   in_rx_byte,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [tksd_pkg::KIND_W-1:0]   out_key_kind,
  input wire logic [tksd_pkg::BYTE_W-1:0]   out_char_value
);

  // a waiting input word stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_rx_byte))
    else $error("input word changed while waiting");

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_kind) && $stable(out_char_value))
    else $error("result word changed while stalled");

  // special keys carry no character
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_kind != tksd_pkg::KIND_REGULAR |-> out_char_value == '0)
    else $error("nonzero char_value on a special key");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_key_kind <= tksd_pkg::KIND_MAX)
    else $error("key_kind out of range");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_rx_byte     (in_rx_byte),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_key_kind   (out_key_kind),
  .out_char_value (out_char_value)
);

`default_nettype wire

>>> tb/tb.sv
// tb: self-checking testbench for terminal_key_sequence_decoder
// drives terminal bytes over valid/ready and checks each decoded key word against
// a local key sequence matcher; depends on tksd_pkg and the design top level
`timescale 1ns / 100ps

module tb;

  localparam int DIR_COUNT   = 25;
  localparam int ITEM_TARGET = 1050;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic [31:0]                 code;  // first byte in [31:24]
    logic [2:0]                  len;
    logic [tksd_pkg::KIND_W-1:0] kind;
  } key_row_t;

  typedef struct packed {
    logic                        emit;
    logic [tksd_pkg::KIND_W-1:0] kind;
    logic [7:0]                  chr;
  } key_word_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;  // expected word written in the row, else from the matcher
    key_word_t  word;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [tksd_pkg::BYTE_W-1:0] in_rx_byte;
  logic out_valid;
  logic out_ready;
  logic [tksd_pkg::KIND_W-1:0] out_key_kind;
  logic [tksd_pkg::BYTE_W-1:0] out_char_value;

  key_row_t  key_rows [tksd_pkg::KEY_COUNT];
  dir_row_t  dir_rows [DIR_COUNT];
  key_word_t pending_keys [$];

  int held_entry;
  int held_pos;
  int sent_count;
  int err_count;
  int idle_cycles;
  int tx_idle_pct;
  int rx_idle_pct;

  terminal_key_sequence_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_key_kind   (out_key_kind),
    .out_char_value (out_char_value)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [7:0] row_byte(input int j, input int k);
    return key_rows[j].code[31-8*k -: 8];
  endfunction

  // full-prefix matcher, lowest table row wins
  function automatic key_word_t decode_key_byte(input logic [7:0] b);
    key_word_t w;
    int j;
    int k;
    int hit;
    logic ok;
    w = '0;
    hit = -1;
    for (j = 0; j < tksd_pkg::KEY_COUNT; j++) begin
      ok = (hit < 0) && (held_pos < int'(key_rows[j].len));
      for (k = 0; k < 3; k++) begin
        if (k < held_pos && row_byte(j, k) != row_byte(held_entry, k)) ok = 1'b0;
      end
      if (ok && row_byte(j, held_pos) == b) hit = j;
    end
    if (hit < 0) begin
      held_entry = 0;
      held_pos = 0;
      w.emit = 1'b1;
      w.kind = tksd_pkg::KIND_REGULAR;
      w.chr = b;
    end else if (held_pos + 1 >= int'(key_rows[hit].len)) begin
      held_entry = 0;
      held_pos = 0;
      w.emit = 1'b1;
      w.kind = key_rows[hit].kind;
      w.chr = 8'h00;
    end else begin
      held_entry = hit;
      held_pos = held_pos + 1;
    end
    return w;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed, input key_word_t typed_word);
    key_word_t w;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    w = decode_key_byte(b);
    if (typed) w = typed_word;
    if (w.emit) pending_keys.push_back(w);
    sent_count++;
  endtask

  // hold the sender off until every expected word has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_keys.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    key_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_keys.size() == 0) begin
        $display("%0t: unexpected word, expected none, got kind %0d char %0h",
                 $time, out_key_kind, out_char_value);
        err_count++;
      end else begin
        exp_w = pending_keys.pop_front();
        if (out_key_kind !== exp_w.kind) begin
          $display("%0t: key_kind expected %0d, got %0d", $time, exp_w.kind, out_key_kind);
          err_count++;
        end
        if (out_char_value !== exp_w.chr) begin
          $display("%0t: char_value expected %0h, got %0h", $time, exp_w.chr, out_char_value);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int k;
    int j;
    int n;
    int r;
    int phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    out_ready = 1'b0;
    held_entry = 0;
    held_pos = 0;
    sent_count = 0;
    err_count = 0;
    idle_cycles = 0;
    tx_idle_pct = 7;
    rx_idle_pct = 54;
    phase = 0;

    key_rows[0]  = {32'h01000000, 3'd1, tksd_pkg::KIND_CTRL_A};
    key_rows[1]  = {32'h02000000, 3'd1, tksd_pkg::KIND_CTRL_B};
    key_rows[2]  = {32'h03000000, 3'd1, tksd_pkg::KIND_CTRL_C};
    key_rows[3]  = {32'h04000000, 3'd1, tksd_pkg::KIND_CTRL_D};
    key_rows[4]  = {32'h05000000, 3'd1, tksd_pkg::KIND_CTRL_E};
    key_rows[5]  = {32'h06000000, 3'd1, tksd_pkg::KIND_CTRL_F};
    key_rows[6]  = {32'h08000000, 3'd1, tksd_pkg::KIND_BKSP};
    key_rows[7]  = {32'h0b000000, 3'd1, tksd_pkg::KIND_CTRL_K};
    key_rows[8]  = {32'h0d000000, 3'd1, tksd_pkg::KIND_ENTER};
    key_rows[9]  = {32'h0e000000, 3'd1, tksd_pkg::KIND_CTRL_N};
    key_rows[10] = {32'h10000000, 3'd1, tksd_pkg::KIND_CTRL_P};
    key_rows[11] = {32'h1b5b317e, 3'd4, tksd_pkg::KIND_HOME};
    key_rows[12] = {32'h1b5b327e, 3'd4, tksd_pkg::KIND_INS};
    key_rows[13] = {32'h1b5b337e, 3'd4, tksd_pkg::KIND_DEL};
    key_rows[14] = {32'h1b304600, 3'd3, tksd_pkg::KIND_END};
    key_rows[15] = {32'h1b5b347e, 3'd4, tksd_pkg::KIND_END};
    key_rows[16] = {32'h1b5b357e, 3'd4, tksd_pkg::KIND_PGUP};
    key_rows[17] = {32'h1b5b367e, 3'd4, tksd_pkg::KIND_PGDN};
    key_rows[18] = {32'h1b5b4100, 3'd3, tksd_pkg::KIND_UP};
    key_rows[19] = {32'h1b5b4200, 3'd3, tksd_pkg::KIND_DOWN};
    key_rows[20] = {32'h1b5b4300, 3'd3, tksd_pkg::KIND_RIGHT};
    key_rows[21] = {32'h1b5b4400, 3'd3, tksd_pkg::KIND_LEFT};

    dir_rows[0]  = {8'h00, 1'b1, 1'b1, tksd_pkg::KIND_REGULAR, 8'h00};
    dir_rows[1]  = {8'hff, 1'b1, 1'b1, tksd_pkg::KIND_REGULAR, 8'hff};
    dir_rows[2]  = {8'h01, 1'b1, 1'b1, tksd_pkg::KIND_CTRL_A, 8'h00};
    dir_rows[3]  = {8'h02, 1'b1, 1'b1, tksd_pkg::KIND_CTRL_B, 8'h00};
    dir_rows[4]  = {8'h03, 1'b1, 1'b1, tksd_pkg::KIND_CTRL_C, 8'h00};
    dir_rows[5]  = {8'h04, 1'b1, 1'b1, tksd_pkg::KIND_CTRL_D, 8'h00};
    dir_rows[6]  = {8'h05, 1'b1, 1'b1, tksd_pkg::KIND_CTRL_E, 8'h00};
    dir_rows[7]  = {8'h06, 1'b1, 1'b1, tksd_pkg::KIND_CTRL_F, 8'h00};
    dir_rows[8]  = {tksd_pkg::CH_BS, 1'b1, 1'b1, tksd_pkg::KIND_BKSP, 8'h00};
    dir_rows[9]  = {tksd_pkg::CH_VT, 1'b1, 1'b1, tksd_pkg::KIND_CTRL_K, 8'h00};
    dir_rows[10] = {tksd_pkg::CH_CR, 1'b1, 1'b1, tksd_pkg::KIND_ENTER, 8'h00};
    dir_rows[11] = {tksd_pkg::CH_SO, 1'b1, 1'b1, tksd_pkg::KIND_CTRL_N, 8'h00};
    dir_rows[12] = {tksd_pkg::CH_DLE, 1'b1, 1'b1, tksd_pkg::KIND_CTRL_P, 8'h00};
    dir_rows[13] = {tksd_pkg::CH_ESC, 1'b0, 1'b0, tksd_pkg::KIND_REGULAR, 8'h00};
    dir_rows[14] = {tksd_pkg::CH_LBRK, 1'b0, 1'b0, tksd_pkg::KIND_REGULAR, 8'h00};
    dir_rows[15] = {8'h31, 1'b0, 1'b0, tksd_pkg::KIND_REGULAR, 8'h00};
    dir_rows[16] = {tksd_pkg::CH_TILDE, 1'b1, 1'b1, tksd_pkg::KIND_HOME, 8'h00};
    dir_rows[17] = {tksd_pkg::CH_ESC, 1'b0, 1'b0, tksd_pkg::KIND_REGULAR, 8'h00};
    dir_rows[18] = {tksd_pkg::CH_ZERO, 1'b0, 1'b0, tksd_pkg::KIND_REGULAR, 8'h00};
    dir_rows[19] = {tksd_pkg::CH_F, 1'b1, 1'b1, tksd_pkg::KIND_END, 8'h00};
    // ESC 0 A must not decode as up arrow: the whole prefix has to match
    dir_rows[20] = {tksd_pkg::CH_ESC, 1'b0, 1'b0, tksd_pkg::KIND_REGULAR, 8'h00};
    dir_rows[21] = {tksd_pkg::CH_ZERO, 1'b0, 1'b0, tksd_pkg::KIND_REGULAR, 8'h00};
    dir_rows[22] = {8'h41, 1'b1, 1'b1, tksd_pkg::KIND_REGULAR, 8'h41};
    // second escape drops the prefix and comes out as a plain character
    dir_rows[23] = {tksd_pkg::CH_ESC, 1'b0, 1'b0, tksd_pkg::KIND_REGULAR, 8'h00};
    dir_rows[24] = {tksd_pkg::CH_ESC, 1'b1, 1'b1, tksd_pkg::KIND_REGULAR, tksd_pkg::CH_ESC};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_COUNT; i++) begin
      send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].word);
    end
    drain_results();

    while (sent_count < ITEM_TARGET) begin
      if (phase == 0 && sent_count >= 375) begin
        drain_results();
        tx_idle_pct = 54;
        rx_idle_pct = 7;
        phase = 1;
      end else if (phase == 1 && sent_count >= 725) begin
        drain_results();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        phase = 2;
      end
      r = $urandom_range(99);
      j = $urandom_range(tksd_pkg::KEY_COUNT - 1);
      if (r < 45) begin
        // well-formed key sequence
        for (k = 0; k < int'(key_rows[j].len); k++) send_byte(row_byte(j, k), 1'b0, '0);
      end else if (r < 65) begin
        // escape prefix cut short by an arbitrary byte
        j = $urandom_range(tksd_pkg::KEY_COUNT - 1, 11);
        n = $urandom_range(int'(key_rows[j].len) - 1, 1);
        for (k = 0; k < n; k++) send_byte(row_byte(j, k), 1'b0, '0);
        send_byte(8'($urandom_range(255)), 1'b0, '0);
      end else if (r < 80) begin
        send_byte(row_byte(j, $urandom_range(int'(key_rows[j].len) - 1)), 1'b0, '0);
      end else begin
        send_byte(8'($urandom_range(255)), 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (err_count == 0 && pending_keys.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/tksd_pkg.sv
design/tksd_matcher.sv
design/terminal_key_sequence_decoder.sv
design/tksd_checker.sv
tb/tb.sv
